FILE: design/assert_macros.svh
// Assertion macros shared by the extent router RTL.
// Depends on nothing; define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: design/srer_pkg.sv
// Package for the sector request extent router: sizes, opcodes and action codes.
// Depends on nothing; imported by sector_request_extent_router_unit.
`default_nettype none

package srer_pkg;

    // Extent table depth.
    localparam int MAX_EXTENTS = 16;

    // Field widths fixed by the request format.
    localparam int SECTOR_W = 28;
    localparam int CARD_W   = 32;
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 4;
    localparam int ENTRY_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    // Width of an effective extent count (0 .. MAX_EXTENTS).
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_ENTRIES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ENABLE   = 2'd3;

    // Result actions.
    typedef enum logic [2:0] {
        ACT_READ       = 3'd0,
        ACT_IMAGE_ONLY = 3'd1,
        ACT_CARD       = 3'd2,
        ACT_RANGE      = 3'd3,
        ACT_UNMAPPED   = 3'd4
    } action_t;

endpackage

`default_nettype wire

FILE: design/sector_request_extent_router_unit.sv
// Top level of the sector request extent router: request pipeline and extent table.
// Depends on srer_pkg and assert_macros.svh.
//
//  Channel  | Direction | Handshake         | Carries
//  s_       | in        | s_valid / s_ready | opcode, lba, extent slot load fields
//  m_       | out       | m_valid / m_ready | action, card_addr, sector
//  cfg_     | in        | cfg_we            | cfg_index, cfg_data
//
// One request per cycle while the output is not held; a read or write result passes
// the range check, the extent match and the card address add into the output register.
// An extent load reaches the table as it leaves stage A, so older requests
// never see it and younger ones always do; loads and unused opcodes give no result.
// All stages advance together: when the output holds an untaken result, the whole
// pipeline and s_ready hold, so nothing is dropped or repeated.
// Reset is synchronous, active low, and clears the configuration and settings registers
// and all valid bits; the pipeline data registers and the extent table are not cleared.
`default_nettype none

`include "assert_macros.svh"

module sector_request_extent_router_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [srer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [srer_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [srer_pkg::OP_W-1:0]         s_opcode,
    input  wire logic [srer_pkg::SECTOR_W-1:0]     s_lba,
    input  wire logic [srer_pkg::SLOT_W-1:0]       s_slot,
    input  wire logic [srer_pkg::SECTOR_W-1:0]     s_slot_start,
    input  wire logic [srer_pkg::SECTOR_W-1:0]     s_slot_length,
    input  wire logic [srer_pkg::CARD_W-1:0]       s_slot_card_base,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [2:0]                             m_action,
    output logic [srer_pkg::CARD_W-1:0]            m_card_addr,
    output logic [srer_pkg::SECTOR_W-1:0]          m_sector
);
    import srer_pkg::*;

    // Configuration registers.
    logic [SECTOR_W-1:0] image_size_reg;
    logic [SECTOR_W-1:0] header_base_reg;
    logic [ENTRY_W-1:0]  extent_entries_reg;
    logic                write_enable_reg;

    // Settings derived from the configuration, registered once.
    logic [SECTOR_W-1:0]    hb_eff_reg, hb_eff_next;
    logic [MAX_EXTENTS-1:0] en_mask_reg, en_mask_next;
    logic                   writable_reg, writable_next;
    logic [CNT_W-1:0]       count_eff;

    // Extent table: end is start plus length, offset is card base minus start.
    logic [SECTOR_W-1:0] ext_start_reg  [MAX_EXTENTS];
    logic [SECTOR_W:0]   ext_end_reg    [MAX_EXTENTS];
    logic [CARD_W-1:0]   ext_offset_reg [MAX_EXTENTS];

    // Pipeline control.
    logic advance;
    logic s_fire;
    logic load_fire;

    // Stage A: captured request.
    logic                valid_a_reg;
    logic                write_a_reg;
    logic [SECTOR_W-1:0] lba_a_reg;
    logic                load_a_reg;
    logic [SLOT_W-1:0]   ld_slot_a_reg;
    logic [SECTOR_W-1:0] ld_start_a_reg;
    logic [SECTOR_W:0]   ld_end_a_reg;
    logic [CARD_W-1:0]   ld_offset_a_reg;

    // Stage B: range results and file sector.
    logic                valid_b_reg;
    logic                write_b_reg;
    logic                range_b_reg, range_b_next;
    logic                below_b_reg, below_b_next;
    logic [SECTOR_W-1:0] fsec_b_reg, fsec_b_next;
    logic [SECTOR_W-1:0] lba_b_reg;

    // Stage C: extent match result.
    logic                valid_c_reg;
    logic                write_c_reg;
    logic                range_c_reg;
    logic                below_c_reg;
    logic [SECTOR_W-1:0] fsec_c_reg;
    logic [SECTOR_W-1:0] lba_c_reg;
    logic                hit_c_reg, hit_c_next;
    logic [CARD_W-1:0]   offset_c_reg, offset_c_next;

    // Output stage.
    logic                m_valid_reg;
    action_t             action_reg, action_next;
    logic [CARD_W-1:0]   card_reg, card_next;
    logic [SECTOR_W-1:0] sector_out_reg;

    // All stages move together whenever the output register is free.
    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = advance;
    assign s_fire    = s_valid && advance;
    assign load_fire = s_fire && (s_opcode == OP_LOAD);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg     <= '0;
            header_base_reg    <= '0;
            extent_entries_reg <= '0;
            write_enable_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_SIZE:     image_size_reg     <= cfg_data[SECTOR_W-1:0];
                REG_HEADER_BASE:    header_base_reg    <= cfg_data[SECTOR_W-1:0];
                REG_EXTENT_ENTRIES: extent_entries_reg <= cfg_data[ENTRY_W-1:0];
                REG_WRITE_ENABLE:   write_enable_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective header base, extent count mask and write permission.
    always_comb begin
        hb_eff_next = (header_base_reg < image_size_reg) ? header_base_reg : '0;
        if (int'(extent_entries_reg) > MAX_EXTENTS) begin
            count_eff = '0;
        end else begin
            count_eff = CNT_W'(extent_entries_reg);
        end
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            en_mask_next[i] = (int'(count_eff) > i);
        end
        writable_next = write_enable_reg && (count_eff != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hb_eff_reg   <= '0;
            en_mask_reg  <= '0;
            writable_reg <= 1'b0;
        end else begin
            hb_eff_reg   <= hb_eff_next;
            en_mask_reg  <= en_mask_next;
            writable_reg <= writable_next;
        end
    end

    // Extent slot loads commit as the load leaves stage A, after every older
    // request has already made its extent compare.
    always_ff @(posedge aclk) begin
        if (advance && load_a_reg) begin
            ext_start_reg[ld_slot_a_reg]  <= ld_start_a_reg;
            ext_end_reg[ld_slot_a_reg]    <= ld_end_a_reg;
            ext_offset_reg[ld_slot_a_reg] <= ld_offset_a_reg;
        end
    end

    // Pipeline valid bits; only reads and writes produce results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            load_a_reg  <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            valid_a_reg <= s_valid && ((s_opcode == OP_READ) || (s_opcode == OP_WRITE));
            load_a_reg  <= load_fire;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            m_valid_reg <= valid_c_reg;
        end
    end

    // Stage A capture, including the prepared table entry of a load.
    always_ff @(posedge aclk) begin
        if (advance) begin
            write_a_reg     <= (s_opcode == OP_WRITE);
            lba_a_reg       <= s_lba;
            ld_slot_a_reg   <= s_slot;
            ld_start_a_reg  <= s_slot_start;
            ld_end_a_reg    <= {1'b0, s_slot_start} + {1'b0, s_slot_length};
            ld_offset_a_reg <= s_slot_card_base - {{(CARD_W-SECTOR_W){1'b0}}, s_slot_start};
        end
    end

    // Range check against the image and the header, and the file sector.
    always_comb begin
        range_b_next = (lba_a_reg >= image_size_reg);
        below_b_next = (lba_a_reg < hb_eff_reg);
        fsec_b_next  = lba_a_reg - hb_eff_reg;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            write_b_reg <= write_a_reg;
            range_b_reg <= range_b_next;
            below_b_reg <= below_b_next;
            fsec_b_reg  <= fsec_b_next;
            lba_b_reg   <= lba_a_reg;
        end
    end

    // Parallel extent compare with a pick of the lowest matching slot.
    always_comb begin
        logic seen;
        logic hit;
        seen          = 1'b0;
        offset_c_next = '0;
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            hit = en_mask_reg[i] && (fsec_b_reg >= ext_start_reg[i]) &&
                  ({1'b0, fsec_b_reg} < ext_end_reg[i]);
            if (hit && !seen) begin
                offset_c_next = ext_offset_reg[i];
            end
            seen = seen | hit;
        end
        hit_c_next = seen;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            write_c_reg  <= write_b_reg;
            range_c_reg  <= range_b_reg;
            below_c_reg  <= below_b_reg;
            fsec_c_reg   <= fsec_b_reg;
            lba_c_reg    <= lba_b_reg;
            hit_c_reg    <= hit_c_next;
            offset_c_reg <= offset_c_next;
        end
    end

    // Action decision and card address.
    always_comb begin
        card_next = '0;
        if (range_c_reg) begin
            action_next = ACT_RANGE;
        end else if (!write_c_reg) begin
            action_next = ACT_READ;
        end else if (below_c_reg) begin
            action_next = ACT_IMAGE_ONLY;
        end else if (!writable_reg || !hit_c_reg) begin
            action_next = ACT_UNMAPPED;
        end else begin
            action_next = ACT_CARD;
            card_next   = offset_c_reg + {{(CARD_W-SECTOR_W){1'b0}}, fsec_c_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            action_reg     <= action_next;
            card_reg       <= card_next;
            sector_out_reg <= lba_c_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_action    = action_reg;
    assign m_card_addr = card_reg;
    assign m_sector    = sector_out_reg;

    // Checks on the routing decision.
    `ASSERT_CLK(a_card_zero, aclk, aresetn, (m_valid && (m_action != ACT_CARD)) |-> (m_card_addr == '0), "card address without a card write")
    `ASSERT_CLK(a_card_writable, aclk, aresetn, (m_valid && (m_action == ACT_CARD)) |-> writable_reg, "card write while writes are disabled")
    `ASSERT_CLK(a_range, aclk, aresetn, m_valid |-> ((m_action == ACT_RANGE) == (m_sector >= image_size_reg)), "range abort disagrees with image size")
    `ASSERT_CLK(a_header, aclk, aresetn, (m_valid && (m_action == ACT_IMAGE_ONLY)) |-> (m_sector < hb_eff_reg), "image-only write above the header base")
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid_reg && !valid_a_reg, "pipeline not empty after reset")

endmodule

`default_nettype wire
